// ===== rtl/nut_pkg.sv =====
`timescale 1ns / 1ps

package nut_pkg;

    localparam int NODES     = 4096;
    localparam int VARIABLES = 1024;
    localparam int IDX_W     = 12;
    localparam int PTR_W     = 13;
    localparam int VAR_W     = 10;
    localparam int OPC_W     = 4;
    localparam int LIMIT_W   = 11;

    localparam logic [PTR_W-1:0] EMPTY_MARK = PTR_W'(NODES);
    localparam logic [31:0]      HASH_PRIME = 32'd1088619811;
    localparam logic [31:0]      HASH_PRIME2 = 32'd2177239622;

    localparam logic OP_FIND    = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [2:0] ST_FOUND   = 3'd0;
    localparam logic [2:0] ST_DONE    = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_BAD     = 3'd3;
    localparam logic [2:0] ST_MISSING = 3'd4;

    localparam logic [2:0] REG_VARIABLE_LIMIT = 3'd0;

    typedef struct packed {
        logic             op;
        logic [VAR_W-1:0] variable;
        logic [OPC_W-1:0] node_operator;
        logic [IDX_W-1:0] low_child;
        logic [IDX_W-1:0] high_child;
        logic [IDX_W-1:0] node_index;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0] result_node;
        logic [2:0]       status;
        logic [PTR_W-1:0] nodes_in_use;
        logic [PTR_W-1:0] peak_in_use;
    } result_t;

    typedef struct packed {
        logic [VAR_W-1:0] variable;
        logic [OPC_W-1:0] opc;
        logic [IDX_W-1:0] low;
        logic [IDX_W-1:0] high;
        logic             free;
        logic [PTR_W-1:0] next;
    } node_word_t;

endpackage

// ===== rtl/node_unique_table.sv =====
`timescale 1ns / 1ps

// Hash-consed node store. After reset the block sweeps both memories, one entry a
// cycle, with busy high. A find hashes the item, reads the bucket head and walks
// the chain; on a miss it checks the limits and inserts from the free list. A
// release reads the released node, hashes it, walks the chain up to it, unlinks it
// and frees it. The chain walk does one node-memory read per cycle. Results come
// as a one-cycle done strobe and cannot be held off by the receiver; the next item
// can be accepted in the strobe cycle.
module node_unique_table (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  nut_pkg::item_t        item,
    output logic                  done,
    output nut_pkg::result_t      result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import nut_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RISSUE, S_RNODE, S_MUL1, S_SUM1, S_MUL2, S_SUM2,
        S_RED1, S_RED2, S_HEAD, S_HEADD, S_FWALK, S_FCHK, S_FPOP, S_RWALK, S_RFREE
    } state_t;

    localparam logic [PTR_W-1:0] NODES_P = PTR_W'(NODES);

    node_word_t        node_mem [NODES];
    logic [PTR_W-1:0]  head_mem [NODES];

    node_word_t        node_rd_q;
    logic [PTR_W-1:0]  head_rd_q;
    logic [IDX_W-1:0]  node_rd_addr;
    logic              node_we;
    logic [IDX_W-1:0]  node_wa;
    node_word_t        node_wd;
    logic              head_we;
    logic [IDX_W-1:0]  head_wa;
    logic [PTR_W-1:0]  head_wd;

    state_t            state_reg;
    logic [IDX_W-1:0]  clear_idx_reg;
    item_t             item_reg;
    node_word_t        uword_reg;
    logic [VAR_W-1:0]  h_var_reg;
    logic [OPC_W-1:0]  h_opc_reg;
    logic [IDX_W-1:0]  h_lo_reg;
    logic [IDX_W-1:0]  h_hi_reg;
    logic [26:0]       prod1_reg;
    logic [25:0]       s2_reg;
    logic [31:0]       prod2_reg;
    logic [31:0]       hv_reg;
    logic [IDX_W-1:0]  bucket_reg;
    logic [PTR_W-1:0]  head_reg;
    logic [IDX_W-1:0]  cur_reg;
    logic [PTR_W-1:0]  visits_reg;
    logic [PTR_W-1:0]  free_head_reg;
    logic [PTR_W-1:0]  free_count_reg;
    logic [PTR_W-1:0]  high_water_reg;
    logic [LIMIT_W-1:0] limit_reg;
    result_t           result_reg;
    logic              done_reg;

    logic [13:0]       key;
    logic [12:0]       s1;
    logic [24:0]       cantor1;
    logic [PTR_W-1:0]  visits_next;
    logic [PTR_W-1:0]  fc_dec;
    logic [PTR_W-1:0]  in_use_ins;
    logic              walk_match;
    logic              cfg_write;

    assign key        = {h_var_reg, h_opc_reg};
    assign s1         = {1'b0, h_lo_reg} + {1'b0, h_hi_reg};
    assign cantor1    = prod1_reg[25:1] + {13'd0, h_lo_reg};
    assign visits_next = visits_reg + 1'b1;
    assign fc_dec     = free_count_reg - 1'b1;
    assign in_use_ins = NODES_P - fc_dec;
    assign walk_match = node_rd_q.variable == item_reg.variable
                     && node_rd_q.opc == item_reg.node_operator
                     && node_rd_q.low == item_reg.low_child
                     && node_rd_q.high == item_reg.high_child;

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = result_reg;
    assign pready = 1'b1;
    assign prdata = (paddr == REG_VARIABLE_LIMIT) ? {21'd0, limit_reg} : 32'd0;
    assign cfg_write = psel && penable && pwrite && (paddr == REG_VARIABLE_LIMIT);

    always_comb
    begin
        case (state_reg)
            S_RISSUE:          node_rd_addr = item_reg.node_index;
            S_HEADD:           node_rd_addr = head_rd_q[IDX_W-1:0];
            S_FWALK, S_RWALK:  node_rd_addr = node_rd_q.next[IDX_W-1:0];
            S_FCHK:            node_rd_addr = free_head_reg[IDX_W-1:0];
            default:           node_rd_addr = cur_reg;
        endcase
    end

    always_comb
    begin
        node_we = 1'b0;
        node_wa = cur_reg;
        node_wd = node_rd_q;
        head_we = 1'b0;
        head_wa = bucket_reg;
        head_wd = EMPTY_MARK;
        case (state_reg)
            S_CLEAR:
            begin
                node_we = 1'b1;
                node_wa = clear_idx_reg;
                node_wd.variable = '0;
                node_wd.opc = '0;
                node_wd.low = (clear_idx_reg == IDX_W'(0)) ? IDX_W'(0) :
                              (clear_idx_reg == IDX_W'(1)) ? IDX_W'(1) :
                              clear_idx_reg + 1'b1;
                node_wd.high = (clear_idx_reg == IDX_W'(1)) ? IDX_W'(1) : IDX_W'(0);
                node_wd.free = clear_idx_reg >= IDX_W'(2);
                node_wd.next = EMPTY_MARK;
                head_we = 1'b1;
                head_wa = clear_idx_reg;
                head_wd = EMPTY_MARK;
            end
            S_FPOP:
            begin
                node_we = 1'b1;
                node_wa = free_head_reg[IDX_W-1:0];
                node_wd.variable = item_reg.variable;
                node_wd.opc = item_reg.node_operator;
                node_wd.low = item_reg.low_child;
                node_wd.high = item_reg.high_child;
                node_wd.free = 1'b0;
                node_wd.next = head_reg;
                head_we = 1'b1;
                head_wd = free_head_reg;
            end
            S_HEADD:
            begin
                if (item_reg.op == OP_RELEASE && head_rd_q == {1'b0, item_reg.node_index})
                begin
                    head_we = 1'b1;
                    head_wd = uword_reg.next;
                end
            end
            S_RWALK:
            begin
                if (node_rd_q.next == {1'b0, item_reg.node_index})
                begin
                    node_we = 1'b1;
                    node_wa = cur_reg;
                    node_wd.next = uword_reg.next;
                end
            end
            S_RFREE:
            begin
                node_we = 1'b1;
                node_wa = item_reg.node_index;
                node_wd = uword_reg;
                node_wd.next = EMPTY_MARK;
                node_wd.free = 1'b1;
                node_wd.low = free_head_reg[IDX_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_wa] <= node_wd;
        end
        node_rd_q <= node_mem[node_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_wa] <= head_wd;
        end
        head_rd_q <= head_mem[bucket_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
        end
        else if (cfg_write)
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clear_idx_reg  <= '0;
            free_head_reg  <= PTR_W'(2);
            free_count_reg <= NODES_P - PTR_W'(2);
            high_water_reg <= PTR_W'(2);
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clear_idx_reg <= clear_idx_reg + 1'b1;
                    if (clear_idx_reg == IDX_W'(NODES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        item_reg  <= item;
                        h_var_reg <= item.variable;
                        h_opc_reg <= item.node_operator;
                        h_lo_reg  <= item.low_child;
                        h_hi_reg  <= item.high_child;
                        if (item.op == OP_FIND)
                        begin
                            state_reg <= S_MUL1;
                        end
                        else if (item.node_index < IDX_W'(2))
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= '{'0, ST_BAD, NODES_P - free_count_reg,
                                            high_water_reg};
                        end
                        else
                        begin
                            state_reg <= S_RISSUE;
                        end
                    end
                end
                S_RISSUE:
                begin
                    state_reg <= S_RNODE;
                end
                S_RNODE:
                begin
                    if (node_rd_q.free)
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '{'0, ST_BAD, NODES_P - free_count_reg,
                                        high_water_reg};
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        uword_reg <= node_rd_q;
                        h_var_reg <= node_rd_q.variable;
                        h_opc_reg <= node_rd_q.opc;
                        h_lo_reg  <= node_rd_q.low;
                        h_hi_reg  <= node_rd_q.high;
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1:
                begin
                    prod1_reg <= {14'd0, s1} * {14'd0, s1 + 1'b1};
                    state_reg <= S_SUM1;
                end
                S_SUM1:
                begin
                    s2_reg    <= {1'b0, cantor1} + {12'd0, key};
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    prod2_reg <= {6'd0, s2_reg} * ({6'd0, s2_reg} + 32'd1);
                    state_reg <= S_SUM2;
                end
                S_SUM2:
                begin
                    hv_reg    <= {1'b0, prod2_reg[31:1]} + {18'd0, key};
                    state_reg <= S_RED1;
                end
                S_RED1:
                begin
                    // sum stays below twice the prime, so this subtract never fires
                    if (hv_reg >= HASH_PRIME2)
                    begin
                        hv_reg <= hv_reg - HASH_PRIME2;
                    end
                    state_reg <= S_RED2;
                end
                S_RED2:
                begin
                    bucket_reg <= (hv_reg >= HASH_PRIME) ? IDX_W'(hv_reg - HASH_PRIME)
                                                         : hv_reg[IDX_W-1:0];
                    state_reg  <= S_HEAD;
                end
                S_HEAD:
                begin
                    state_reg <= S_HEADD;
                end
                S_HEADD:
                begin
                    head_reg   <= head_rd_q;
                    cur_reg    <= head_rd_q[IDX_W-1:0];
                    visits_reg <= '0;
                    if (item_reg.op == OP_FIND)
                    begin
                        state_reg <= head_rd_q[PTR_W-1] ? S_FCHK : S_FWALK;
                    end
                    else if (head_rd_q == {1'b0, item_reg.node_index})
                    begin
                        state_reg <= S_RFREE;
                    end
                    else if (head_rd_q[PTR_W-1])
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '{'0, ST_MISSING, NODES_P - free_count_reg,
                                        high_water_reg};
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_RWALK;
                    end
                end
                S_FWALK:
                begin
                    visits_reg <= visits_next;
                    cur_reg    <= node_rd_q.next[IDX_W-1:0];
                    if (walk_match)
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '{cur_reg, ST_FOUND, NODES_P - free_count_reg,
                                        high_water_reg};
                        state_reg  <= S_IDLE;
                    end
                    else if (node_rd_q.next[PTR_W-1] || visits_next == NODES_P)
                    begin
                        state_reg <= S_FCHK;
                    end
                end
                S_FCHK:
                begin
                    if ({1'b0, item_reg.variable} >= limit_reg
                        || 32'(item_reg.variable) >= 32'(VARIABLES))
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '{'0, ST_BAD, NODES_P - free_count_reg,
                                        high_water_reg};
                        state_reg  <= S_IDLE;
                    end
                    else if (free_count_reg == '0 || free_head_reg >= NODES_P)
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '{'0, ST_FULL, NODES_P - free_count_reg,
                                        high_water_reg};
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_FPOP;
                    end
                end
                S_FPOP:
                begin
                    free_head_reg  <= {1'b0, node_rd_q.low};
                    free_count_reg <= fc_dec;
                    if (high_water_reg < in_use_ins)
                    begin
                        high_water_reg <= in_use_ins;
                    end
                    done_reg   <= 1'b1;
                    result_reg <= '{free_head_reg[IDX_W-1:0], ST_DONE, in_use_ins,
                                    (high_water_reg < in_use_ins) ? in_use_ins
                                                                  : high_water_reg};
                    state_reg  <= S_IDLE;
                end
                S_RWALK:
                begin
                    visits_reg <= visits_next;
                    cur_reg    <= node_rd_q.next[IDX_W-1:0];
                    if (node_rd_q.next == {1'b0, item_reg.node_index})
                    begin
                        state_reg <= S_RFREE;
                    end
                    else if (node_rd_q.next[PTR_W-1] || visits_next == NODES_P)
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '{'0, ST_MISSING, NODES_P - free_count_reg,
                                        high_water_reg};
                        state_reg  <= S_IDLE;
                    end
                end
                S_RFREE:
                begin
                    free_head_reg  <= {1'b0, item_reg.node_index};
                    free_count_reg <= free_count_reg + 1'b1;
                    done_reg       <= 1'b1;
                    result_reg     <= '{'0, ST_DONE, NODES_P - free_count_reg - 1'b1,
                                        high_water_reg};
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result beat while an item is still in flight");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done_reg)
        else $error("accepted item neither started nor answered");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= NODES_P - PTR_W'(2))
        else $error("free count covers a terminal node");

    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        high_water_reg >= NODES_P - free_count_reg)
        else $error("peak below nodes in use");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RFREE |-> $past(state_reg) == S_HEADD || $past(state_reg) == S_RWALK)
        else $error("release freed a node without unlinking it");

endmodule
